FILE: design/sawlc_pkg.sv
// Shared types and codes for the set-associative write-back cache.
`default_nettype none
package sawlc_pkg;

	localparam int BYTE_W  = 8;
	localparam int LINE_W  = 64;
	localparam int LADDR_W = 29;
	localparam int KIND_W  = 3;
	localparam int MODE_W  = 2;

	localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_READ      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WRITEBACK = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REFILL    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REFUSED   = 3'd4;

	localparam logic [1:0] ST_INVALID = 2'd0;
	localparam logic [1:0] ST_CLEAN   = 2'd1;
	localparam logic [1:0] ST_DIRTY   = 2'd2;

	typedef struct packed {
		logic clear_wr;   // write a zero metadata row during the reset sweep
		logic capture;    // take the input word, start the row read
		logic lookup;     // row data valid: evaluate, update, load results
		logic sel_first;  // present the writeback slot
	} sawlc_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic two_results;
	} sawlc_stat_t;

endpackage
`default_nettype wire

FILE: design/set_assoc_writeback_lru_cache_top.sv
// Top level of the set-associative write-back write-allocate LRU cache.
//
//  channel | dir | handshake          | word
//  in      | in  | in_valid/in_ready   | mode, byte_address, write_byte, fill_line
//  out     | out | out_valid/out_ready | kind, hit, read_byte, line_address, line_data, last
//
// An item goes through accept and row read, lookup and RAM update, and then
// one or two result words. The row RAMs have one registered read port, which
// sets the lookup cycle. After reset a sweep clears all 2^SET_INDEX_BITS
// tag/age/status rows; in_ready stays low until it ends. Output stalls hold
// the block.
`default_nettype none
module set_assoc_writeback_lru_cache_top import sawlc_pkg::*; #(
	parameter int SET_INDEX_BITS   = 6,
	parameter int LINE_OFFSET_BITS = 3,
	parameter int WAYS             = 8,
	parameter int ADDRESS_BITS     = 32,
	parameter int AGE_BITS         = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic [31:0]        byte_address,
	input  wire logic [BYTE_W-1:0]  write_byte,
	input  wire logic [LINE_W-1:0]  fill_line,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [KIND_W-1:0]  kind,
	output logic                    hit,
	output logic      [BYTE_W-1:0]  read_byte,
	output logic      [LADDR_W-1:0] line_address,
	output logic      [LINE_W-1:0]  line_data,
	output logic                    last
);
	sawlc_cmd_t  cmd;
	sawlc_stat_t stat;

	sawlc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	sawlc_dp #(
		.SET_INDEX_BITS(SET_INDEX_BITS), .LINE_OFFSET_BITS(LINE_OFFSET_BITS),
		.WAYS(WAYS), .ADDRESS_BITS(ADDRESS_BITS), .AGE_BITS(AGE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.mode(mode), .byte_address(byte_address), .write_byte(write_byte),
		.fill_line(fill_line), .kind(kind), .hit(hit), .read_byte(read_byte),
		.line_address(line_address), .line_data(line_data), .last(last)
	);
endmodule
`default_nettype wire

FILE: design/sawlc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sawlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: design/sawlc_ctrl.sv
// Sequencer: reset sweep, accept, lookup, result emission.
`default_nettype none
module sawlc_ctrl import sawlc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire sawlc_stat_t stat,
	output sawlc_cmd_t       cmd
);
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_EMIT0,
		S_EMIT1
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (stat.clear_last) state_q <= S_IDLE;
				S_IDLE:  if (in_valid) state_q <= S_LOOK;
				S_LOOK:  state_q <= stat.two_results ? S_EMIT0 : S_EMIT1;
				S_EMIT0: if (out_ready) state_q <= S_EMIT1;
				S_EMIT1: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = (state_q == S_EMIT0) || (state_q == S_EMIT1);
	assign cmd.clear_wr  = (state_q == S_CLEAR);
	assign cmd.capture   = (state_q == S_IDLE) && in_valid;
	assign cmd.lookup    = (state_q == S_LOOK);
	assign cmd.sel_first = (state_q == S_EMIT0);
endmodule
`default_nettype wire

FILE: design/sawlc_dp.sv
// Datapath: tag/age/status RAM, line RAM, LRU pick, miss bookkeeping, result slots.
`default_nettype none
module sawlc_dp import sawlc_pkg::*; #(
	parameter int SET_INDEX_BITS   = 6,
	parameter int LINE_OFFSET_BITS = 3,
	parameter int WAYS             = 8,
	parameter int ADDRESS_BITS     = 32,
	parameter int AGE_BITS         = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sawlc_cmd_t          cmd,
	output sawlc_stat_t              stat,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [31:0]         byte_address,
	input  wire logic [BYTE_W-1:0]   write_byte,
	input  wire logic [LINE_W-1:0]   fill_line,
	output logic      [KIND_W-1:0]   kind,
	output logic                     hit,
	output logic      [BYTE_W-1:0]   read_byte,
	output logic      [LADDR_W-1:0]  line_address,
	output logic      [LINE_W-1:0]   line_data,
	output logic                     last
);
	localparam int ROWS   = 1 << SET_INDEX_BITS;
	localparam int SW     = SET_INDEX_BITS > 0 ? SET_INDEX_BITS : 1;
	localparam int RW     = ROWS > 1 ? $clog2(ROWS) : 1;
	localparam int OW     = LINE_OFFSET_BITS > 0 ? LINE_OFFSET_BITS : 1;
	localparam int WW     = WAYS > 1 ? $clog2(WAYS) : 1;
	localparam int AW     = ADDRESS_BITS < 32 ? ADDRESS_BITS : 32;
	localparam int TAG_W  = ADDRESS_BITS - SET_INDEX_BITS - LINE_OFFSET_BITS;
	localparam int ENT_W  = 2 + AGE_BITS + TAG_W;
	localparam int META_W = WAYS * ENT_W;
	localparam int DATA_W = WAYS * LINE_W;
	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << AW) - 64'd1);
	localparam logic [SW-1:0] SET_MASK = SW'((64'd1 << SET_INDEX_BITS) - 64'd1);
	localparam logic [OW-1:0] OFF_MASK = OW'((64'd1 << LINE_OFFSET_BITS) - 64'd1);
	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

	function automatic logic [SW-1:0] set_of(input logic [31:0] a);
		return SW'(a >> LINE_OFFSET_BITS) & SET_MASK;
	endfunction
	function automatic logic [OW-1:0] off_of(input logic [31:0] a);
		return a[OW-1:0] & OFF_MASK;
	endfunction
	function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
		return TAG_W'((a & ADDR_MASK) >> (LINE_OFFSET_BITS + SET_INDEX_BITS));
	endfunction
	function automatic logic [LINE_W-1:0] merge(input logic [LINE_W-1:0] line,
			input logic [OW-1:0] off, input logic [BYTE_W-1:0] b);
		logic [5:0] sh;
		sh = 6'({off, 3'b000});
		return (line & ~(LINE_W'(8'hFF) << sh)) | (LINE_W'(b) << sh);
	endfunction
	function automatic logic [BYTE_W-1:0] pick(input logic [LINE_W-1:0] line,
			input logic [OW-1:0] off);
		logic [5:0] sh;
		sh = 6'({off, 3'b000});
		return BYTE_W'(line >> sh);
	endfunction

	// captured input word
	logic [MODE_W-1:0] mode_q;
	logic [31:0]       addr_q;
	logic [BYTE_W-1:0] wbyte_q;
	logic [LINE_W-1:0] fill_q;
	// outstanding miss
	logic              pend_q;
	logic [31:0]       pend_addr_q;
	logic [BYTE_W-1:0] pend_byte_q;
	logic              pend_wr_q;
	logic [WW-1:0]     pend_way_q;
	logic [RW-1:0]     clr_q;
	// result slots: 0 holds a writeback, 1 the final result
	logic [KIND_W-1:0]  kind0_q, kind1_q;
	logic               hit1_q;
	logic [BYTE_W-1:0]  rbyte1_q;
	logic [LADDR_W-1:0] laddr0_q, laddr1_q;
	logic [LINE_W-1:0]  data0_q;

	logic [META_W-1:0] meta_rd, meta_new, meta_wdata;
	logic [DATA_W-1:0] data_rd, data_new;
	logic [RW-1:0]     rd_row, wr_row, meta_waddr;
	logic              meta_we, data_we;

	logic [1:0]          st [WAYS];
	logic [AGE_BITS-1:0] age [WAYS];
	logic [TAG_W-1:0]    tg [WAYS];
	logic [AGE_BITS-1:0] age_inc [WAYS];
	logic [AGE_BITS-1:0] best;
	logic [WW-1:0]       max_way, inv_way, hit_way, vic_way;
	logic                have_inv, hit_f, is_acc, is_fill, is_wr;
	logic [LINE_W-1:0]   vic_line, hit_line;
	logic [63:0]         vline;

	assign rd_row = RW'((mode == MODE_FILL) ? set_of(pend_addr_q) : set_of(byte_address));
	assign is_fill = (mode_q == MODE_FILL) && pend_q;
	assign is_acc  = (mode_q == MODE_READ || mode_q == MODE_WRITE) && !pend_q;
	assign is_wr   = (mode_q == MODE_WRITE);
	assign wr_row  = RW'(is_fill ? set_of(pend_addr_q) : set_of(addr_q));

	sawlc_ram #(.WIDTH(META_W), .DEPTH(ROWS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
		.raddr(rd_row), .rdata(meta_rd)
	);
	sawlc_ram #(.WIDTH(DATA_W), .DEPTH(ROWS)) u_data (
		.clk(clk), .we(data_we), .waddr(wr_row), .wdata(data_new),
		.raddr(rd_row), .rdata(data_rd)
	);

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			tg[w]  = meta_rd[w*ENT_W +: TAG_W];
			age[w] = meta_rd[w*ENT_W + TAG_W +: AGE_BITS];
			st[w]  = meta_rd[w*ENT_W + TAG_W + AGE_BITS +: 2];
			age_inc[w] = (age[w] == AGE_MAX) ? age[w] : age[w] + 1'b1;
		end
		// first way with the greatest age
		best = age_inc[0];
		max_way = '0;
		for (int w = 1; w < WAYS; w++) begin
			if (age_inc[w] > best) begin
				best = age_inc[w];
				max_way = WW'(w);
			end
		end
		// last invalid way, first matching way
		have_inv = 1'b0;
		inv_way = '0;
		hit_f = 1'b0;
		hit_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (st[w] == ST_INVALID) begin
				have_inv = 1'b1;
				inv_way = WW'(w);
			end
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (st[w] != ST_INVALID && tg[w] == tag_of(addr_q)) begin
				hit_f = 1'b1;
				hit_way = WW'(w);
			end
		end
		vic_way  = have_inv ? inv_way : max_way;
		vic_line = data_rd[int'(vic_way)*LINE_W +: LINE_W];
		hit_line = data_rd[int'(hit_way)*LINE_W +: LINE_W];
		vline    = (64'(tg[vic_way]) << SET_INDEX_BITS) | 64'(set_of(addr_q));

		meta_new = meta_rd;
		data_new = data_rd;
		if (is_acc) begin
			for (int w = 0; w < WAYS; w++) begin
				meta_new[w*ENT_W + TAG_W +: AGE_BITS] = age_inc[w];
			end
			if (hit_f) begin
				meta_new[int'(hit_way)*ENT_W + TAG_W +: AGE_BITS] = '0;
				if (is_wr) begin
					meta_new[int'(hit_way)*ENT_W + TAG_W + AGE_BITS +: 2] = ST_DIRTY;
					data_new[int'(hit_way)*LINE_W +: LINE_W] =
						merge(hit_line, off_of(addr_q), wbyte_q);
				end
			end else begin
				meta_new[int'(vic_way)*ENT_W + TAG_W + AGE_BITS +: 2] = ST_INVALID;
			end
		end
		if (is_fill) begin
			meta_new[int'(pend_way_q)*ENT_W +: ENT_W] =
				{pend_wr_q ? ST_DIRTY : ST_CLEAN, {AGE_BITS{1'b0}}, tag_of(pend_addr_q)};
			data_new[int'(pend_way_q)*LINE_W +: LINE_W] = pend_wr_q ?
				merge(fill_q, off_of(pend_addr_q), pend_byte_q) : fill_q;
		end
	end

	assign meta_we    = cmd.clear_wr || (cmd.lookup && (is_acc || is_fill));
	assign meta_waddr = cmd.clear_wr ? clr_q : wr_row;
	assign meta_wdata = cmd.clear_wr ? '0 : meta_new;
	assign data_we    = cmd.lookup && (is_fill || (is_acc && hit_f && is_wr));

	assign stat.clear_last  = (clr_q == RW'(ROWS - 1));
	assign stat.two_results = is_acc && !hit_f && (st[vic_way] == ST_DIRTY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			clr_q  <= '0;
		end else begin
			if (cmd.clear_wr) clr_q <= clr_q + 1'b1;
			if (cmd.lookup) begin
				if (is_fill) pend_q <= 1'b0;
				else if (is_acc && !hit_f) pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			addr_q  <= byte_address;
			wbyte_q <= write_byte;
			fill_q  <= fill_line;
		end
		if (cmd.lookup) begin
			if (is_acc && !hit_f) begin
				pend_addr_q <= addr_q;
				pend_byte_q <= wbyte_q;
				pend_wr_q   <= is_wr;
				pend_way_q  <= vic_way;
			end
			kind0_q  <= KIND_WRITEBACK;
			laddr0_q <= LADDR_W'(vline);
			data0_q  <= vic_line;
			hit1_q   <= 1'b0;
			rbyte1_q <= '0;
			laddr1_q <= '0;
			if (is_fill) begin
				kind1_q <= pend_wr_q ? KIND_WRITE : KIND_READ;
				if (!pend_wr_q) rbyte1_q <= pick(fill_q, off_of(pend_addr_q));
			end else if (is_acc && hit_f) begin
				kind1_q <= is_wr ? KIND_WRITE : KIND_READ;
				hit1_q  <= 1'b1;
				if (!is_wr) rbyte1_q <= pick(hit_line, off_of(addr_q));
			end else if (is_acc) begin
				kind1_q  <= KIND_REFILL;
				laddr1_q <= LADDR_W'((addr_q & ADDR_MASK) >> LINE_OFFSET_BITS);
			end else begin
				kind1_q <= KIND_REFUSED;
			end
		end
	end

	assign kind         = cmd.sel_first ? kind0_q : kind1_q;
	assign hit          = cmd.sel_first ? 1'b0 : hit1_q;
	assign read_byte    = cmd.sel_first ? '0 : rbyte1_q;
	assign line_address = cmd.sel_first ? laddr0_q : laddr1_q;
	assign line_data    = cmd.sel_first ? data0_q : '0;
	assign last         = !cmd.sel_first;
endmodule
`default_nettype wire

FILE: design/sawlc_checker.sv
// Port-level checks for the cache top, attached by bind.
`default_nettype none
module sawlc_checker import sawlc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [KIND_W-1:0]  kind,
	input wire logic               hit,
	input wire logic               last
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while a result is pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
		else $error("stalled result word changed");

	a_wb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_WRITEBACK) |-> !last && !hit)
		else $error("writeback flagged last");

	a_wb_then_refill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && (kind == KIND_REFILL) && last)
		else $error("writeback not followed by refill request");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_REFUSED || kind == KIND_REFILL) |-> last && !hit)
		else $error("bad refused or refill word");
endmodule

bind set_assoc_writeback_lru_cache_top sawlc_checker u_sawlc_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .kind(kind), .hit(hit), .last(last)
);
`default_nettype wire

FILE: verif/tb_set_assoc_writeback_lru_cache_top.sv
// Testbench for the set-associative write-back LRU cache: directed and random accesses checked against a predictor.
`default_nettype none
module tb_set_assoc_writeback_lru_cache_top;
	import sawlc_pkg::*;

	localparam int SETS = 64;
	localparam int NWAYS = 8;
	localparam int AGE_MAX = 65535;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic               hit;
		logic [BYTE_W-1:0]  read_byte;
		logic [LADDR_W-1:0] line_address;
		logic [LINE_W-1:0]  line_data;
		logic               last;
	} result_t;

	// cache predictor with its own copy of the tag, age, status and data rows
	class cache_scoreboard;
		logic [1:0]        status[SETS*NWAYS];
		int unsigned       age[SETS*NWAYS];
		logic [22:0]       tag[SETS*NWAYS];
		logic [LINE_W-1:0] data[SETS*NWAYS];
		bit                waiting_fill;
		logic [31:0]       pend_addr;
		logic [7:0]        pend_byte;
		bit                pend_wr;
		int                pend_way;
		result_t           expected_words[$];
		int                errors;

		function new();
			for (int i = 0; i < SETS*NWAYS; i++) begin
				status[i] = ST_INVALID;
				age[i] = 0;
				tag[i] = '0;
				data[i] = '0;
			end
			waiting_fill = 0;
			errors = 0;
		endfunction

		function void push(logic [2:0] k, logic h, logic [7:0] rb, logic [28:0] la,
				logic [63:0] ld, logic l);
			result_t r;
			r.kind = k; r.hit = h; r.read_byte = rb; r.line_address = la;
			r.line_data = ld; r.last = l;
			expected_words.push_back(r);
		endfunction

		function void note_input(logic [1:0] md, logic [31:0] a, logic [7:0] wb,
				logic [63:0] fl);
			int off, st, idx, victim, inv, best;
			bit have_inv, found;
			logic [22:0] tg;
			if (md == MODE_FILL && waiting_fill) begin
				off = pend_addr[2:0];
				idx = pend_addr[8:3] * NWAYS + pend_way;
				tag[idx] = pend_addr[31:9];
				age[idx] = 0;
				waiting_fill = 0;
				if (pend_wr) begin
					data[idx] = fl;
					data[idx][8*off +: 8] = pend_byte;
					status[idx] = ST_DIRTY;
					push(KIND_WRITE, 0, 0, 0, 0, 1);
				end else begin
					data[idx] = fl;
					status[idx] = ST_CLEAN;
					push(KIND_READ, 0, fl[8*off +: 8], 0, 0, 1);
				end
				return;
			end
			if (md > MODE_WRITE || waiting_fill) begin
				push(KIND_REFUSED, 0, 0, 0, 0, 1);
				return;
			end
			off = a[2:0];
			st = a[8:3];
			tg = a[31:9];
			victim = 0; inv = 0; best = 0; have_inv = 0; found = 0;
			for (int w = 0; w < NWAYS; w++) begin
				idx = st*NWAYS + w;
				if (age[idx] < AGE_MAX) age[idx]++;
				if (w == 0 || age[idx] > best) begin
					best = age[idx];
					victim = w;
				end
				if (status[idx] == ST_INVALID) begin
					inv = w;
					have_inv = 1;
				end
			end
			for (int w = 0; w < NWAYS && !found; w++) begin
				idx = st*NWAYS + w;
				if (status[idx] != ST_INVALID && tag[idx] == tg) begin
					found = 1;
					age[idx] = 0;
					if (md == MODE_WRITE) begin
						data[idx][8*off +: 8] = wb;
						status[idx] = ST_DIRTY;
						push(KIND_WRITE, 1, 0, 0, 0, 1);
					end else
						push(KIND_READ, 1, data[idx][8*off +: 8], 0, 0, 1);
				end
			end
			if (found) return;
			if (have_inv) victim = inv;
			idx = st*NWAYS + victim;
			if (status[idx] == ST_DIRTY)
				push(KIND_WRITEBACK, 0, 0, {tag[idx], 6'(st)}, data[idx], 0);
			status[idx] = ST_INVALID;
			push(KIND_REFILL, 0, 0, a[31:3], 0, 1);
			waiting_fill = 1;
			pend_addr = a; pend_byte = wb; pend_wr = (md == MODE_WRITE); pend_way = victim;
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (expected_words.size() == 0) begin
				$error("unexpected result word kind=%0d", got.kind);
				errors++;
				return;
			end
			e = expected_words.pop_front();
			if (got.kind != e.kind) begin
				$error("kind: expected %0d actual %0d", e.kind, got.kind); errors++;
			end
			if (got.hit != e.hit) begin
				$error("hit: expected %0d actual %0d", e.hit, got.hit); errors++;
			end
			if (got.read_byte != e.read_byte) begin
				$error("read_byte: expected %h actual %h", e.read_byte, got.read_byte); errors++;
			end
			if (got.line_address != e.line_address) begin
				$error("line_address: expected %h actual %h", e.line_address,
					got.line_address);
				errors++;
			end
			if (got.line_data != e.line_data) begin
				$error("line_data: expected %h actual %h", e.line_data, got.line_data);
				errors++;
			end
			if (got.last != e.last) begin
				$error("last: expected %0d actual %0d", e.last, got.last); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [MODE_W-1:0] mode;
	logic [31:0] byte_address;
	logic [BYTE_W-1:0] write_byte;
	logic [LINE_W-1:0] fill_line;
	logic [KIND_W-1:0] kind;
	logic hit, last;
	logic [BYTE_W-1:0] read_byte;
	logic [LADDR_W-1:0] line_address;
	logic [LINE_W-1:0] line_data;

	cache_scoreboard sb;
	int unsigned cycle_count;
	bit calm;      // no idling in the final stretch
	bit hold_sink; // long receiver hold-off

	set_assoc_writeback_lru_cache_top DUT (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stall bursts, plus one long hold-off
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink)
				out_ready <= 0;
			else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 6);
				out_ready <= 0;
				repeat (gap - 1) @(posedge clk);
			end else
				out_ready <= 1;
		end
	end

	always @(posedge clk)
		if (out_valid && out_ready)
			sb.check_result('{kind, hit, read_byte, line_address, line_data, last});

	// valid stays up from one word to the next unless an idle burst comes between
	task automatic send_word(logic [1:0] md, logic [31:0] a, logic [7:0] wb, logic [63:0] fl);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		mode <= md; byte_address <= a; write_byte <= wb; fill_line <= fl;
		do @(posedge clk); while (!in_ready);
		sb.note_input(md, a, wb, fl);
	endtask

	function automatic logic [63:0] rand_line();
		return {$urandom, $urandom};
	endfunction

	// access followed by a fill when it misses
	task automatic access(logic [1:0] md, logic [31:0] a, logic [7:0] wb);
		send_word(md, a, wb, rand_line());
		if (sb.waiting_fill)
			send_word(MODE_FILL, $urandom, 8'($urandom), rand_line());
	endtask

	// addresses drawn from a small tag pool on a few sets to get hits and evictions
	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(0, 9) != 0) begin
			a[31:9] = {$urandom_range(0, 1) ? 23'h7fffff : 23'h0} ^ 23'($urandom_range(0, 11));
			a[8:3] = $urandom_range(0, 2) == 0 ? 6'h3f : 6'($urandom_range(0, 2));
		end
		return a;
	endfunction

	initial begin
		in_valid = 0; mode = MODE_READ; byte_address = 0; write_byte = 0; fill_line = 0;
		calm = 0; hold_sink = 0; cycle_count = 0;
		sb = new();
		@(posedge arst_n);
		@(posedge clk);
		// directed: stray fill, reserved mode, extremes, refused during miss
		send_word(MODE_FILL, 32'hffffffff, 8'hff, 64'hffffffffffffffff);
		send_word(2'd3, 32'h0, 8'h0, 64'h0);
		send_word(MODE_READ, 32'h0, 8'h0, 64'h0);
		send_word(MODE_WRITE, 32'h12345678, 8'haa, 64'h0);
		send_word(2'd3, 32'h0, 8'h0, 64'h0);
		send_word(MODE_FILL, 32'h0, 8'h0, 64'h0);
		access(MODE_WRITE, 32'hffffffff, 8'hff);
		access(MODE_READ, 32'hffffffff, 8'h0);
		access(MODE_WRITE, 32'h00000007, 8'h5a);
		access(MODE_READ, 32'h00000007, 8'h0);
		// fill one set with dirty lines past the way count to force writebacks
		for (int t = 0; t < 10; t++)
			access(MODE_WRITE, {23'(t + 100), 6'h3f, 3'(t)}, 8'(t * 17));
		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_sink = 1;
				repeat (60) @(posedge clk);
				hold_sink = 0;
			end
			for (int i = 0; i < 12; i++)
				access(2'($urandom_range(0, 1)), pick_addr(), 8'($urandom));
		join
		for (int i = 0; i < 320; i++) begin
			if (i == 270) calm = 1;
			case ($urandom_range(0, 19))
				0: send_word(MODE_FILL, $urandom, 8'($urandom), rand_line());
				1: send_word(2'd3, $urandom, 8'($urandom), rand_line());
				2: begin
					send_word(2'($urandom_range(0, 1)), pick_addr(), 8'($urandom),
						rand_line());
					if (sb.waiting_fill)
						send_word(2'($urandom_range(0, 1)), pick_addr(), 8'($urandom),
							rand_line());
				end
				default: access(2'($urandom_range(0, 1)), pick_addr(), 8'($urandom));
			endcase
		end
		if (sb.waiting_fill)
			send_word(MODE_FILL, '0, '0, rand_line());
		in_valid <= 0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
